// ===== hw/rtl/adx_pkg.sv =====
// ----------------------------------------------------------------------------
// adx_pkg
// Shared widths, constants, control-word types and the microcode ROM of the
// ADX indicator step block.
// ----------------------------------------------------------------------------
package adx_pkg;

  // Number formats
  localparam int PRICE_BITS   = 32;                      // unsigned Q16.F prices
  localparam int FRAC_BITS    = 16;                      // fraction bits
  localparam int ALPHA_BITS   = 16;                      // alpha is always Q0.16
  localparam int PERIOD_BITS  = 10;
  localparam int COUNT_BITS   = PERIOD_BITS + 1;         // bar count, up to period+1
  localparam int RATIO_BITS   = FRAC_BITS + 1;           // 0 .. 1.0
  localparam int DX_INT_BITS  = 7;                       // 0 .. 100 integer part
  localparam int ADX_BITS     = FRAC_BITS + DX_INT_BITS; // Q7.F
  localparam int SUM_BITS     = RATIO_BITS + 1;
  localparam int COEF_BITS    = ALPHA_BITS + 1;          // alpha or 1-alpha
  localparam int ACC_BITS     = COEF_BITS + ADX_BITS;
  localparam int DIV_BITS     = (PRICE_BITS > SUM_BITS) ? PRICE_BITS : SUM_BITS;
  localparam int DIV_CNT_BITS = $clog2(ADX_BITS + 1);
  localparam int DX_SCALE     = 100;

  // Stream and config port widths
  localparam int IN_DATA_BITS   = ((3 * PRICE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((ADX_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = (PERIOD_BITS > ALPHA_BITS) ? PERIOD_BITS : ALPHA_BITS;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA  = 1'b1;

  // Reset values and fixed-point constants
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = ALPHA_BITS'(8738);
  localparam logic [RATIO_BITS-1:0]  RATIO_ONE    = RATIO_BITS'(1) << FRAC_BITS;
  localparam logic [ADX_BITS-1:0]    ADX_MAX      = ADX_BITS'(DX_SCALE) << FRAC_BITS;
  localparam logic [COEF_BITS-1:0]   ALPHA_ONE    = COEF_BITS'(1) << ALPHA_BITS;

  // Sequencer steps (ROM addresses)
  localparam int STEP_BITS = 5;
  typedef enum logic [STEP_BITS-1:0] {
    S_IDLE, S_PREP, S_DIVP_LOAD, S_DIVP_RUN, S_DIVN_LOAD, S_DIVN_RUN,
    S_NR_STORE, S_MULB_P, S_WR_P, S_MULB_N, S_WR_N, S_DX_LOAD, S_DX_RUN,
    S_DX_STORE, S_MULA_X, S_MULB_X, S_FINISH, S_OUT
  } step_t;

  // How the step counter moves on
  typedef enum logic [2:0] {
    J_NEXT,     // step + 1
    J_WAIT_IN,  // hold until a request is accepted
    J_SEED,     // to target on a series start, else step + 1
    J_DIV,      // hold until the divider's last iteration
    J_OUT,      // hold while the output register is full, then to target
    J_JUMP      // to target
  } jmp_t;

  typedef enum logic [1:0] {M_NONE, M_LOAD, M_ADD} mul_op_t;
  typedef enum logic [1:0] {SRC_P, SRC_N, SRC_X} src_t;
  typedef enum logic [2:0] {D_NONE, D_RATIO_P, D_RATIO_N, D_DX, D_ITER} div_op_t;
  typedef enum logic [3:0] {
    W_NONE, W_PREP, W_PR, W_NR, W_PI, W_MI, W_DX, W_FINISH, W_OUT
  } wr_t;

  // Datapath control field of a control word
  typedef struct packed {
    mul_op_t mul;
    src_t    src;
    div_op_t div;
    wr_t     wr;
  } uctl_t;

  typedef struct packed {
    jmp_t  jmp;
    step_t target;
    uctl_t ctl;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic seed;
    logic div_last;
    logic out_full;
  } stat_t;

  // Divider command
  typedef struct packed {
    logic                    load;
    logic                    iter;
    logic [DIV_BITS-1:0]     num;
    logic [DIV_BITS-1:0]     den;
    logic [ADX_BITS-1:0]     bits;
    logic [DIV_CNT_BITS-1:0] count;
  } div_cmd_t;

  // Microcode ROM
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{jmp: J_NEXT, target: S_IDLE,
          ctl: '{mul: M_NONE, src: SRC_P, div: D_NONE, wr: W_NONE}};
    case (s)
      S_IDLE:      w.jmp = J_WAIT_IN;
      S_PREP: begin
        w.jmp    = J_SEED;
        w.target = S_OUT;
        w.ctl.wr = W_PREP;
      end
      S_DIVP_LOAD: w.ctl.div = D_RATIO_P;
      S_DIVP_RUN: begin
        w.jmp     = J_DIV;
        w.ctl.div = D_ITER;
      end
      S_DIVN_LOAD: begin
        w.ctl.wr  = W_PR;
        w.ctl.div = D_RATIO_N;
      end
      S_DIVN_RUN: begin
        w.jmp     = J_DIV;
        w.ctl.div = D_ITER;
      end
      S_NR_STORE: begin
        w.ctl.wr  = W_NR;
        w.ctl.mul = M_LOAD;
        w.ctl.src = SRC_P;
      end
      S_MULB_P: begin
        w.ctl.mul = M_ADD;
        w.ctl.src = SRC_P;
      end
      S_WR_P: begin
        w.ctl.wr  = W_PI;
        w.ctl.mul = M_LOAD;
        w.ctl.src = SRC_N;
      end
      S_MULB_N: begin
        w.ctl.mul = M_ADD;
        w.ctl.src = SRC_N;
      end
      S_WR_N:      w.ctl.wr = W_MI;
      S_DX_LOAD:   w.ctl.div = D_DX;
      S_DX_RUN: begin
        w.jmp     = J_DIV;
        w.ctl.div = D_ITER;
      end
      S_DX_STORE:  w.ctl.wr = W_DX;
      S_MULA_X: begin
        w.ctl.mul = M_LOAD;
        w.ctl.src = SRC_X;
      end
      S_MULB_X: begin
        w.ctl.mul = M_ADD;
        w.ctl.src = SRC_X;
      end
      S_FINISH:    w.ctl.wr = W_FINISH;
      S_OUT: begin
        w.jmp    = J_OUT;
        w.target = S_IDLE;
        w.ctl.wr = W_OUT;
      end
      default: begin
        w.jmp    = J_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/adx_div.sv =====
// ----------------------------------------------------------------------------
// adx_div
// Restoring serial divider, one quotient bit per cycle. The partial remainder
// is loaded directly; further dividend bits shift in MSB first.
// ----------------------------------------------------------------------------
module adx_div (
  input  logic                          clk,
  input  logic                          rst,
  input  adx_pkg::div_cmd_t             cmd,
  output logic [adx_pkg::ADX_BITS-1:0]  quo,
  output logic                          last
);

  logic [adx_pkg::DIV_BITS-1:0]     rem;
  logic [adx_pkg::DIV_BITS-1:0]     dvs;
  logic [adx_pkg::ADX_BITS-1:0]     dvd;
  logic [adx_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [adx_pkg::DIV_BITS:0]       trial;
  logic [adx_pkg::DIV_BITS:0]       trial_sub;
  logic                             fits;

  // One trial subtraction
  always_comb begin
    trial     = {rem, dvd[adx_pkg::ADX_BITS-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
    last      = (cnt == adx_pkg::DIV_CNT_BITS'(1));
  end

  // Iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= cmd.count;
    end else if (cmd.iter && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder, divisor, dividend and quotient
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= cmd.num;
      dvs <= cmd.den;
      dvd <= cmd.bits;
      quo <= '0;
    end else if (cmd.iter) begin
      rem <= fits ? trial_sub[adx_pkg::DIV_BITS-1:0] : trial[adx_pkg::DIV_BITS-1:0];
      dvd <= {dvd[adx_pkg::ADX_BITS-2:0], 1'b0};
      quo <= {quo[adx_pkg::ADX_BITS-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/adx_dp.sv =====
// ----------------------------------------------------------------------------
// adx_dp
// Datapath: config registers, bar history, true range and directional moves,
// shared smoothing multiplier, divider control and the output register.
// ----------------------------------------------------------------------------
module adx_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  adx_pkg::uctl_t                       ctl,
  input  logic                                 in_fire,
  input  logic [adx_pkg::PRICE_BITS-1:0]       bar_high,
  input  logic [adx_pkg::PRICE_BITS-1:0]       bar_low,
  input  logic [adx_pkg::PRICE_BITS-1:0]       bar_close,
  input  logic                                 series_start,
  input  logic                                 cfg_we,
  input  logic [adx_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [adx_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output adx_pkg::stat_t                       stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [adx_pkg::ADX_BITS-1:0]         adx_value,
  output logic                                 adx_valid
);

  // Config
  logic [adx_pkg::PERIOD_BITS-1:0] period;
  logic [adx_pkg::ALPHA_BITS-1:0]  alpha;

  // Captured request
  logic [adx_pkg::PRICE_BITS-1:0] in_high, in_low, in_close;
  logic                           in_start;

  // Series state
  logic [adx_pkg::PRICE_BITS-1:0] last_high, last_low, last_close;
  logic [adx_pkg::RATIO_BITS-1:0] plus_index, minus_index;
  logic [adx_pkg::ADX_BITS-1:0]   smoothed_adx;
  logic [adx_pkg::COUNT_BITS-1:0] bars_seen;

  // Work registers
  logic [adx_pkg::PRICE_BITS-1:0] tr, pdm, ndm;
  logic [adx_pkg::RATIO_BITS-1:0] plus_ratio, minus_ratio;
  logic [adx_pkg::ADX_BITS-1:0]   dx;
  logic                           sat;
  logic [adx_pkg::ACC_BITS-1:0]   acc;
  logic [adx_pkg::ADX_BITS-1:0]   res_value;
  logic                           res_valid;

  // Combinational terms
  logic [adx_pkg::PERIOD_BITS-1:0] per_eff;
  logic [adx_pkg::COUNT_BITS-1:0]  limit;
  logic [adx_pkg::COUNT_BITS-1:0]  bars_inc;
  logic                            first;
  logic                            valid_now;
  logic [adx_pkg::PRICE_BITS-1:0]  top, bot, tr_raw, tr_new;
  logic signed [adx_pkg::PRICE_BITS:0] up, down;
  logic                            up_wins, down_wins;
  logic [adx_pkg::SUM_BITS-1:0]    sum;
  logic [adx_pkg::RATIO_BITS-1:0]  diff;
  logic [adx_pkg::ADX_BITS-1:0]    dx_num;
  logic [adx_pkg::COEF_BITS-1:0]   coef;
  logic [adx_pkg::ADX_BITS-1:0]    opnd;
  logic [adx_pkg::ACC_BITS-1:0]    prod;
  logic [adx_pkg::RATIO_BITS-1:0]  smooth_ratio;
  logic [adx_pkg::ADX_BITS-1:0]    smooth_adx;
  logic [adx_pkg::ADX_BITS-1:0]    adx_new;
  logic [adx_pkg::RATIO_BITS-1:0]  ratio_q;
  logic                            out_load;
  logic [adx_pkg::ADX_BITS-1:0]    quo;
  logic                            div_last;
  adx_pkg::div_cmd_t               div_cmd;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= adx_pkg::PERIOD_RESET;
      alpha  <= adx_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        adx_pkg::REG_PERIOD: period <= cfg_data[adx_pkg::PERIOD_BITS-1:0];
        adx_pkg::REG_ALPHA:  alpha  <= cfg_data[adx_pkg::ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_high  <= bar_high;
      in_low   <= bar_low;
      in_close <= bar_close;
      in_start <= series_start;
    end
  end

  // Bar count, range and moves
  always_comb begin
    per_eff   = (period == '0) ? adx_pkg::PERIOD_BITS'(1) : period;
    limit     = adx_pkg::COUNT_BITS'(per_eff) + 1'b1;
    bars_inc  = bars_seen + 1'b1;
    first     = (bars_seen == adx_pkg::COUNT_BITS'(1));
    valid_now = (bars_seen >= limit);

    top    = (in_high > last_close) ? in_high : last_close;
    bot    = (in_low < last_close) ? in_low : last_close;
    tr_raw = top - bot;
    tr_new = (tr_raw == '0) ? adx_pkg::PRICE_BITS'(1) : tr_raw;

    up        = $signed({1'b0, in_high}) - $signed({1'b0, last_high});
    down      = $signed({1'b0, last_low}) - $signed({1'b0, in_low});
    up_wins   = (up > down) && !up[adx_pkg::PRICE_BITS] && (up != '0);
    down_wins = (down > up) && !down[adx_pkg::PRICE_BITS] && (down != '0);

    stat.seed     = in_start || (bars_seen == '0);
    stat.div_last = div_last;
    stat.out_full = out_valid && !out_ready;
  end

  // DX numerator and denominator
  always_comb begin
    sum    = {1'b0, plus_index} + {1'b0, minus_index};
    diff   = (plus_index > minus_index) ? plus_index - minus_index
                                        : minus_index - plus_index;
    dx_num = adx_pkg::ADX_BITS'(diff) * adx_pkg::ADX_BITS'(adx_pkg::DX_SCALE);
  end

  // Divider commands
  always_comb begin
    div_cmd      = '0;
    div_cmd.iter = (ctl.div == adx_pkg::D_ITER);
    case (ctl.div)
      adx_pkg::D_RATIO_P: begin
        div_cmd.load  = 1'b1;
        div_cmd.num   = adx_pkg::DIV_BITS'(pdm);
        div_cmd.den   = adx_pkg::DIV_BITS'(tr);
        div_cmd.count = adx_pkg::DIV_CNT_BITS'(adx_pkg::FRAC_BITS);
      end
      adx_pkg::D_RATIO_N: begin
        div_cmd.load  = 1'b1;
        div_cmd.num   = adx_pkg::DIV_BITS'(ndm);
        div_cmd.den   = adx_pkg::DIV_BITS'(tr);
        div_cmd.count = adx_pkg::DIV_CNT_BITS'(adx_pkg::FRAC_BITS);
      end
      adx_pkg::D_DX: begin
        // top quotient bits are known zero: start from the partial remainder
        div_cmd.load  = 1'b1;
        div_cmd.num   = adx_pkg::DIV_BITS'(dx_num >> adx_pkg::DX_INT_BITS);
        div_cmd.den   = (sum == '0) ? adx_pkg::DIV_BITS'(1) : adx_pkg::DIV_BITS'(sum);
        div_cmd.bits  = {dx_num[adx_pkg::DX_INT_BITS-1:0], adx_pkg::FRAC_BITS'(0)};
        div_cmd.count = adx_pkg::DIV_CNT_BITS'(adx_pkg::ADX_BITS);
      end
      default: ;
    endcase
  end

  adx_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .quo  (quo),
    .last (div_last)
  );

  // Ratio result, saturating at 1.0
  assign ratio_q = sat ? adx_pkg::RATIO_ONE : {1'b0, quo[adx_pkg::FRAC_BITS-1:0]};

  // Saturation flag for the ratio in flight
  always_ff @(posedge clk) begin
    case (ctl.div)
      adx_pkg::D_RATIO_P: sat <= (pdm >= tr);
      adx_pkg::D_RATIO_N: sat <= (ndm >= tr);
      default: ;
    endcase
  end

  // Smoothing multiplier: alpha*x, then (1-alpha)*old added
  always_comb begin
    coef = (ctl.mul == adx_pkg::M_ADD) ? adx_pkg::ALPHA_ONE - {1'b0, alpha}
                                       : {1'b0, alpha};
    case (ctl.src)
      adx_pkg::SRC_P: opnd = (ctl.mul == adx_pkg::M_ADD) ? adx_pkg::ADX_BITS'(plus_index)
                                                         : adx_pkg::ADX_BITS'(plus_ratio);
      adx_pkg::SRC_N: opnd = (ctl.mul == adx_pkg::M_ADD) ? adx_pkg::ADX_BITS'(minus_index)
                                                         : adx_pkg::ADX_BITS'(minus_ratio);
      adx_pkg::SRC_X: opnd = (ctl.mul == adx_pkg::M_ADD) ? smoothed_adx : dx;
      default:        opnd = '0;
    endcase
    prod         = coef * opnd;
    smooth_ratio = acc[adx_pkg::ALPHA_BITS +: adx_pkg::RATIO_BITS];
    smooth_adx   = acc[adx_pkg::ALPHA_BITS +: adx_pkg::ADX_BITS];
    adx_new      = first ? dx : smooth_adx;
  end

  always_ff @(posedge clk) begin
    case (ctl.mul)
      adx_pkg::M_LOAD: acc <= prod;
      adx_pkg::M_ADD:  acc <= acc + prod;
      default: ;
    endcase
  end

  // Series state and per-bar work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_index   <= '0;
      minus_index  <= '0;
      smoothed_adx <= '0;
      bars_seen    <= '0;
    end else begin
      case (ctl.wr)
        adx_pkg::W_PREP: begin
          if (stat.seed) begin
            last_high    <= in_high;
            last_low     <= in_low;
            last_close   <= in_close;
            plus_index   <= '0;
            minus_index  <= '0;
            smoothed_adx <= '0;
            bars_seen    <= adx_pkg::COUNT_BITS'(1);
            res_value    <= '0;
            res_valid    <= 1'b0;
          end else begin
            tr  <= tr_new;
            pdm <= up_wins ? up[adx_pkg::PRICE_BITS-1:0] : '0;
            ndm <= down_wins ? down[adx_pkg::PRICE_BITS-1:0] : '0;
          end
        end
        adx_pkg::W_PR: plus_ratio  <= ratio_q;
        adx_pkg::W_NR: minus_ratio <= ratio_q;
        adx_pkg::W_PI: plus_index  <= first ? plus_ratio : smooth_ratio;
        adx_pkg::W_MI: minus_index <= first ? minus_ratio : smooth_ratio;
        adx_pkg::W_DX: dx <= quo;
        adx_pkg::W_FINISH: begin
          smoothed_adx <= adx_new;
          bars_seen    <= (bars_inc > limit) ? limit : bars_inc;
          last_high    <= in_high;
          last_low     <= in_low;
          last_close   <= in_close;
          res_value    <= valid_now ? adx_new : '0;
          res_valid    <= valid_now;
        end
        default: ;
      endcase
    end
  end

  // Output register
  assign out_load = (ctl.wr == adx_pkg::W_OUT) && !stat.out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      adx_value <= res_value;
      adx_valid <= res_valid;
    end
  end

  // Checks
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (plus_index <= adx_pkg::RATIO_ONE) && (minus_index <= adx_pkg::RATIO_ONE))
    else $error("directional index above 1.0");

  a_adx_range: assert property (@(posedge clk) disable iff (rst)
    smoothed_adx <= adx_pkg::ADX_MAX)
    else $error("smoothed ADX above 100");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !adx_valid) |-> (adx_value == '0))
    else $error("nonzero ADX on a result marked not valid");

endmodule

// ===== hw/rtl/adx_useq.sv =====
// ----------------------------------------------------------------------------
// adx_useq
// Microcode sequencer: a step counter addresses the control ROM; each word
// drives the datapath and says how the counter moves on.
// ----------------------------------------------------------------------------
module adx_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  adx_pkg::stat_t  stat,
  output adx_pkg::uctl_t  ctl,
  output logic            idle
);

  adx_pkg::step_t  step;
  adx_pkg::step_t  step_next;
  adx_pkg::uword_t word;
  adx_pkg::step_t  step_inc;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= adx_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Next step
  always_comb begin
    step_inc = adx_pkg::step_t'(step + adx_pkg::STEP_BITS'(1));
    case (word.jmp)
      adx_pkg::J_NEXT:    step_next = step_inc;
      adx_pkg::J_WAIT_IN: step_next = in_fire ? step_inc : step;
      adx_pkg::J_SEED:    step_next = stat.seed ? word.target : step_inc;
      adx_pkg::J_DIV:     step_next = stat.div_last ? step_inc : step;
      adx_pkg::J_OUT:     step_next = stat.out_full ? step : word.target;
      adx_pkg::J_JUMP:    step_next = word.target;
      default:            step_next = adx_pkg::S_IDLE;
    endcase
  end

  // Control word
  always_comb begin
    word = adx_pkg::ucode(step);
    ctl  = word.ctl;
    idle = (word.jmp == adx_pkg::J_WAIT_IN);
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (step == adx_pkg::S_PREP))
    else $error("accepted bar did not start the program");

  a_seed_skips: assert property (@(posedge clk) disable iff (rst)
    (step == adx_pkg::S_PREP && stat.seed) |=> (step == adx_pkg::S_OUT))
    else $error("series start did not go straight to output");

endmodule

// ===== hw/rtl/adx_indicator_step.sv =====
// ----------------------------------------------------------------------------
// adx_indicator_step
// ADX indicator over a stream of price bars, one result per bar.
// ----------------------------------------------------------------------------
// One bar (high, low, close) is taken per request and gives one result.
// For a bar that continues a series the shared serial divider runs three
// passes (16, 16 and 23 quotient bits, one bit per cycle), around the steps
// of setup, smoothing multiplies and write-back. A series-start bar (or the
// first bar after reset) skips straight from the setup step to the output.
// A new bar is accepted while the previous result still waits in the output
// register; a result held by the sink stalls the block only when the next
// one is ready. period and alpha are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module adx_indicator_step (
  input  logic                                  clk,
  input  logic                                  rst,
  // bars in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [adx_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // bar_high, bar_low, bar_close
  input  logic                                  s_axis_tuser,  // series_start
  // results out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [adx_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,  // adx_value, zero pad
  output logic                                  m_axis_tuser,  // adx_valid
  // config writes
  input  logic                                  cfg_we,
  input  logic [adx_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [adx_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  adx_pkg::uctl_t               ctl;
  adx_pkg::stat_t               stat;
  logic                         idle;
  logic                         in_fire;
  logic [adx_pkg::ADX_BITS-1:0] adx_value;

  // Request handshake
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;

  adx_useq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .ctl     (ctl),
    .idle    (idle)
  );

  adx_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .in_fire      (in_fire),
    .bar_high     (s_axis_tdata[0 +: adx_pkg::PRICE_BITS]),
    .bar_low      (s_axis_tdata[adx_pkg::PRICE_BITS +: adx_pkg::PRICE_BITS]),
    .bar_close    (s_axis_tdata[2 * adx_pkg::PRICE_BITS +: adx_pkg::PRICE_BITS]),
    .series_start (s_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .adx_value    (adx_value),
    .adx_valid    (m_axis_tuser)
  );

  // Result packing
  assign m_axis_tdata = adx_pkg::OUT_DATA_BITS'(adx_value);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADX indicator step block. Price bars go in as
// stream requests. A behavioral predictor keeps its own copy of the previous
// bar, the smoothed indices and the bar count, and queues one expected result
// per accepted bar. Each result that leaves the block is checked against that
// queue field by field. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [adx_pkg::PRICE_BITS-1:0] high;
    logic [adx_pkg::PRICE_BITS-1:0] low;
    logic [adx_pkg::PRICE_BITS-1:0] close;
    logic                           start;
  } bar_t;

  typedef struct packed {
    logic [adx_pkg::ADX_BITS-1:0] value;
    logic                         valid;
  } adx_result_t;

  localparam int    BLOCK_LATENCY = 70;
  localparam longint PRICE_MAX    = (longint'(1) << adx_pkg::PRICE_BITS) - 1;

  logic clk;
  logic rst = 1'b1;

  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [adx_pkg::IN_DATA_BITS-1:0]   s_axis_tdata  = '0;  // bar_high, bar_low, bar_close
  logic                               s_axis_tuser  = 1'b0; // series_start
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [adx_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;         // adx_value, zero pad
  logic                               m_axis_tuser;         // adx_valid
  logic                               cfg_we        = 1'b0;
  logic [adx_pkg::CFG_INDEX_BITS-1:0] cfg_index     = '0;
  logic [adx_pkg::CFG_DATA_BITS-1:0]  cfg_data      = '0;

  adx_indicator_step dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor copy of configuration and bar history
  logic [adx_pkg::PERIOD_BITS-1:0] cfg_period = adx_pkg::PERIOD_RESET;
  logic [adx_pkg::ALPHA_BITS-1:0]  cfg_alpha  = adx_pkg::ALPHA_RESET;
  logic [adx_pkg::PRICE_BITS-1:0]  prev_high  = '0;
  logic [adx_pkg::PRICE_BITS-1:0]  prev_low   = '0;
  logic [adx_pkg::PRICE_BITS-1:0]  prev_close = '0;
  logic [adx_pkg::RATIO_BITS-1:0]  plus_avg   = '0;
  logic [adx_pkg::RATIO_BITS-1:0]  minus_avg  = '0;
  logic [adx_pkg::ADX_BITS-1:0]    adx_avg    = '0;
  logic [adx_pkg::COUNT_BITS-1:0]  bar_count  = '0;

  adx_result_t adx_pending[$];
  int          mismatches = 0;
  bit          quiet_mode = 1'b0;  // no idle cycles on either side
  longint      walk_close = 0;
  int          sink_hold  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_idle();
    return quiet_mode ? 0 : $urandom_range(0, 3);
  endfunction

  // Q0.16 exponential smoothing, truncated
  function automatic logic [63:0] ema(input logic [63:0] x, input logic [63:0] old);
    logic [63:0] a;
    a = 64'(cfg_alpha);
    return (a * x + ((64'd1 << adx_pkg::ALPHA_BITS) - a) * old) >> adx_pkg::ALPHA_BITS;
  endfunction

  // move / TR with FRAC_BITS fraction bits, capped at 1.0
  function automatic logic [63:0] move_ratio(input logic [63:0] num, input logic [63:0] den);
    if (num >= den) return 64'd1 << adx_pkg::FRAC_BITS;
    return (num << adx_pkg::FRAC_BITS) / den;
  endfunction

  // Advance the shadow state by one bar and return the result it should give
  function automatic adx_result_t predict_adx(input bar_t b);
    logic [63:0] per, limit, top, bot, tr, pdm, ndm, pr, nr, sum, diff, dx, nxt;
    longint      up, down;
    adx_result_t r;
    per   = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
    limit = per + 64'd1;
    r     = '0;

    // series start, or first bar since reset: seed history only
    if (b.start || bar_count == '0) begin
      prev_high  = b.high;
      prev_low   = b.low;
      prev_close = b.close;
      plus_avg   = '0;
      minus_avg  = '0;
      adx_avg    = '0;
      bar_count  = adx_pkg::COUNT_BITS'(1);
      return r;
    end

    top = (b.high > prev_close) ? 64'(b.high) : 64'(prev_close);
    bot = (b.low < prev_close) ? 64'(b.low) : 64'(prev_close);
    tr  = top - bot;
    if (tr == '0) tr = 64'd1;

    // only the strictly larger positive move counts
    up   = longint'(b.high) - longint'(prev_high);
    down = longint'(prev_low) - longint'(b.low);
    pdm  = '0;
    ndm  = '0;
    if (up > down && up > 0) pdm = up;
    if (down > up && down > 0) ndm = down;
    pr = move_ratio(pdm, tr);
    nr = move_ratio(ndm, tr);

    if (bar_count == adx_pkg::COUNT_BITS'(1)) begin
      plus_avg  = adx_pkg::RATIO_BITS'(pr);
      minus_avg = adx_pkg::RATIO_BITS'(nr);
    end else begin
      plus_avg  = adx_pkg::RATIO_BITS'(ema(pr, 64'(plus_avg)));
      minus_avg = adx_pkg::RATIO_BITS'(ema(nr, 64'(minus_avg)));
    end

    sum  = 64'(plus_avg) + 64'(minus_avg);
    diff = (plus_avg > minus_avg) ? 64'(plus_avg - minus_avg) : 64'(minus_avg - plus_avg);
    if (sum == '0) sum = 64'd1;
    dx = ((64'(adx_pkg::DX_SCALE) * diff) << adx_pkg::FRAC_BITS) / sum;

    if (bar_count == adx_pkg::COUNT_BITS'(1)) adx_avg = adx_pkg::ADX_BITS'(dx);
    else adx_avg = adx_pkg::ADX_BITS'(ema(dx, 64'(adx_avg)));

    r.valid   = 64'(bar_count) >= limit;
    nxt       = 64'(bar_count) + 64'd1;
    bar_count = adx_pkg::COUNT_BITS'((nxt > limit) ? limit : nxt);

    prev_high  = b.high;
    prev_low   = b.low;
    prev_close = b.close;

    if (r.valid) r.value = adx_avg;
    return r;
  endfunction

  // Result sink: random back-pressure and field checks
  always @(posedge clk) begin : result_sink
    adx_result_t want;
    int          hold;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (adx_pending.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, got value %0d valid %0b", $time,
                 m_axis_tdata[adx_pkg::ADX_BITS-1:0], m_axis_tuser);
      end else begin
        want = adx_pending.pop_front();
        if (m_axis_tdata[adx_pkg::ADX_BITS-1:0] !== want.value) begin
          mismatches++;
          $display("%0t: adx_value expected %0d, got %0d", $time, want.value,
                   m_axis_tdata[adx_pkg::ADX_BITS-1:0]);
        end
        if (m_axis_tuser !== want.valid) begin
          mismatches++;
          $display("%0t: adx_valid expected %0b, got %0b", $time, want.valid, m_axis_tuser);
        end
      end
      hold = draw_idle();
      m_axis_tready <= (hold == 0);
      sink_hold     <= hold;
    end else if (!m_axis_tready) begin
      m_axis_tready <= (sink_hold <= 1);
      sink_hold     <= (sink_hold > 0) ? sink_hold - 1 : 0;
    end
  end

  // One bar request; the expectation is queued when it is accepted
  task automatic send_bar(input bar_t b);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= adx_pkg::IN_DATA_BITS'({b.close, b.low, b.high});
    s_axis_tuser  <= b.start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    adx_pending.push_back(predict_adx(b));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (adx_pending.size() != 0);
  endtask

  // Write both registers back to back; only call while drained
  task automatic set_config(input logic [adx_pkg::PERIOD_BITS-1:0] p,
                            input logic [adx_pkg::ALPHA_BITS-1:0] a);
    logic [adx_pkg::CFG_DATA_BITS-1:0] word;
    word = adx_pkg::CFG_DATA_BITS'($urandom);  // junk above the period field
    word[adx_pkg::PERIOD_BITS-1:0] = p;
    cfg_we    <= 1'b1;
    cfg_index <= adx_pkg::REG_PERIOD;
    cfg_data  <= word;
    @(posedge clk);
    cfg_period = p;
    cfg_index <= adx_pkg::REG_ALPHA;
    cfg_data  <= adx_pkg::CFG_DATA_BITS'(a);
    @(posedge clk);
    cfg_alpha = a;
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [adx_pkg::ALPHA_BITS-1:0] alpha_for(input int p);
    int pp, q;
    pp = (p == 0) ? 1 : p;
    q  = (131072 + (pp + 1) / 2) / (pp + 1);
    return (q > 65535) ? adx_pkg::ALPHA_BITS'(65535) : adx_pkg::ALPHA_BITS'(q);
  endfunction

  function automatic longint clamp_price(input longint v);
    if (v < 0) return 0;
    if (v > PRICE_MAX) return PRICE_MAX;
    return v;
  endfunction

  // Next bar of a random walk from the last close
  function automatic bar_t walk_bar();
    longint scale, o, c, hi, lo;
    bar_t   b;
    scale = longint'(1) << $urandom_range(2, 26);
    o  = walk_close;
    c  = clamp_price(o + longint'($urandom_range(0, 32'(2 * scale))) - scale);
    hi = clamp_price(((o > c) ? o : c) + longint'($urandom_range(0, 32'(scale))));
    lo = clamp_price(((o < c) ? o : c) - longint'($urandom_range(0, 32'(scale))));
    walk_close = c;
    b.high  = hi[adx_pkg::PRICE_BITS-1:0];
    b.low   = lo[adx_pkg::PRICE_BITS-1:0];
    b.close = c[adx_pkg::PRICE_BITS-1:0];
    b.start = 1'b0;
    return b;
  endfunction

  // Any bit pattern, low possibly above high, occasional restart
  function automatic bar_t noise_bar();
    bar_t b;
    b.high  = adx_pkg::PRICE_BITS'($urandom);
    b.low   = adx_pkg::PRICE_BITS'($urandom);
    b.close = adx_pkg::PRICE_BITS'($urandom);
    b.start = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic extend_series(input int len);
    bar_t b;
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) b = noise_bar();
      else b = walk_bar();
      send_bar(b);
    end
  endtask

  // Fresh walk level (random, near zero or near full scale), then len more bars
  task automatic run_series(input int len, input logic flag_start);
    bar_t b;
    case ($urandom_range(0, 2))
      0:       walk_close = longint'($urandom);
      1:       walk_close = longint'($urandom_range(0, 1 << 20));
      default: walk_close = PRICE_MAX - longint'($urandom_range(0, 1 << 20));
    endcase
    b = walk_bar();
    b.start = flag_start;
    send_bar(b);
    extend_series(len);
  endtask

  // Reset values of period and alpha; first bar carries no start flag
  task automatic test_reset_defaults();
    run_series(16, 1'b0);
  endtask

  task automatic test_corner_bars();
    bar_t b;
    wait_drain();
    set_config('0, '1);  // period zero behaves as one
    b = '{high: '1, low: '1, close: '1, start: 1'b1};
    send_bar(b);
    b = '{high: '0, low: '0, close: '0, start: 1'b0};  // largest down move
    send_bar(b);
    send_bar(b);  // flat bar: TR clamps to one LSB, no moves
    b = '{high: 32'h0000_0100, low: 32'h0000_8000, close: 32'h0000_4000, start: 1'b0};
    send_bar(b);  // low above high
    b = '{high: 32'h0000_0200, low: 32'h0000_7F00, close: 32'h0000_1000, start: 1'b0};
    send_bar(b);  // equal up and down moves, neither counts
    b = '{high: 32'h1001_0000, low: 32'h1000_8000, close: 32'h1000_C000, start: 1'b0};
    send_bar(b);  // up move larger than TR saturates
    b = '{high: '1, low: '0, close: 32'h8000_0000, start: 1'b1};
    send_bar(b);  // restart inside a series
    b = '{high: 32'hFFFF_0000, low: 32'h0001_0000, close: 32'h7FFF_FFFF, start: 1'b0};
    send_bar(b);

    // alpha zero: averages hold the seed
    wait_drain();
    set_config(adx_pkg::PERIOD_BITS'(1), '0);
    run_series(3, 1'b1);

    // widest period stays not valid
    wait_drain();
    set_config('1, adx_pkg::ALPHA_BITS'(1));
    run_series(2, 1'b1);
  endtask

  // Period lowered then raised in the middle of one series
  task automatic test_period_change();
    wait_drain();
    set_config(adx_pkg::PERIOD_BITS'(6), alpha_for(6));
    run_series(10, 1'b1);
    wait_drain();
    set_config(adx_pkg::PERIOD_BITS'(2), alpha_for(2));
    extend_series(4);
    wait_drain();
    set_config(adx_pkg::PERIOD_BITS'(9), alpha_for(9));
    extend_series(8);
  endtask

  task automatic test_random_series();
    int                              sent, len, per_eff;
    logic [adx_pkg::PERIOD_BITS-1:0] p;
    logic [adx_pkg::ALPHA_BITS-1:0]  a;
    sent = 0;
    while (sent < 400) begin
      case ($urandom_range(0, 9))
        0:       p = '1;
        1:       p = '0;
        default: p = adx_pkg::PERIOD_BITS'($urandom_range(1, 16));
      endcase
      per_eff = (p == '0) ? 1 : int'(p);
      case ($urandom_range(0, 7))
        0:       a = adx_pkg::ALPHA_BITS'(1);
        1:       a = '1;
        2:       a = '0;
        3:       a = adx_pkg::ALPHA_BITS'($urandom);
        default: a = alpha_for(per_eff);
      endcase
      wait_drain();
      set_config(p, a);
      quiet_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        len = $urandom_range(1, (per_eff > 28) ? 30 : per_eff + 12);
        run_series(len, $urandom_range(0, 7) != 0);
        sent += len + 1;
        // hold off until everything in flight has returned
        if ($urandom_range(0, 4) == 0) wait_drain();
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_corner_bars();
    test_period_change();
    test_random_series();
    wait_drain();
    // catch any stray result after the last one
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
    if (mismatches == 0 && adx_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
